/* src/aqu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqu_pkg
// Shared types, codes and defaults of the activation quantizer unit.
// ----------------------------------------------------------------------------
package aqu_pkg;

   // default geometry
   localparam int CENTER_SLOTS = 4;
   localparam int DATA_WIDTH   = 16;
   localparam int FRAC_BITS    = 12;

   // fixed register geometry
   localparam int TABLE_WIDTH  = 64;
   localparam int RAW_COUNT_W  = 3;
   localparam int COUNT_W      = 4;
   localparam int CSR_ADDR_W   = 3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FORWARD_MODE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACKWARD_MODE  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NEGATIVE_SLOPE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CLIP_THRESHOLD = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_COUNT   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_TABLE   = 3'd5;

   // reset values
   localparam logic [RAW_COUNT_W-1:0] CENTER_COUNT_RESET = 3'd1;
   localparam logic [TABLE_WIDTH-1:0] CENTER_TABLE_RESET = 64'd4096;

   typedef enum logic [1:0] {
      FWD_SIGN     = 2'd0,
      FWD_HARDTANH = 2'd1,
      FWD_HWGQ     = 2'd2,
      FWD_LEAKY    = 2'd3
   } fwd_mode_type;

   typedef enum logic {
      BWD_CLIP  = 1'b0,
      BWD_LEAKY = 1'b1
   } bwd_mode_type;

   typedef enum logic {
      REQ_FORWARD  = 1'b0,
      REQ_BACKWARD = 1'b1
   } req_kind_type;

   // static controls from the register file
   typedef struct packed {
      fwd_mode_type         fwd_mode;
      bwd_mode_type         bwd_mode;
      logic [COUNT_W-1:0]   center_count;   // clamped to 1..slots
   } ctrl_type;

   // compare results from the first stage
   typedef struct packed {
      logic x_pos;
      logic x_gt_one;
      logic x_lt_mone;
      logic clip_pass;
      logic over_thr;
   } flags_type;

   // result selection for the last stage
   typedef struct packed {
      logic use_prod;
      logic zero;
   } sel_type;

endpackage

/* src/aqu_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqu_csr
// Configuration registers, center count clamp and center table unpacking.
// ----------------------------------------------------------------------------
module aqu_csr #(
   parameter int DW    = aqu_pkg::DATA_WIDTH,
   parameter int SLOTS = aqu_pkg::CENTER_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [aqu_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [aqu_pkg::TABLE_WIDTH-1:0]   csr_wdata,
   output aqu_pkg::ctrl_type                 ctrl,
   output logic signed [DW-1:0]              slope,
   output logic [DW-2:0]                     thr,
   output logic signed [DW-1:0]              centers [SLOTS]
);

   aqu_pkg::fwd_mode_type                 fwd_mode_ff;
   aqu_pkg::bwd_mode_type                 bwd_mode_ff;
   logic signed [DW-1:0]                  slope_ff;
   logic [DW-2:0]                         thr_ff;
   logic [aqu_pkg::RAW_COUNT_W-1:0]       count_ff;
   logic [aqu_pkg::TABLE_WIDTH-1:0]       table_ff;
   logic [aqu_pkg::COUNT_W-1:0]           count_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_mode_ff <= aqu_pkg::FWD_SIGN;
         bwd_mode_ff <= aqu_pkg::BWD_CLIP;
         slope_ff    <= '0;
         thr_ff      <= '0;
         count_ff    <= aqu_pkg::CENTER_COUNT_RESET;
         table_ff    <= aqu_pkg::CENTER_TABLE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            aqu_pkg::CSR_FORWARD_MODE: begin
               fwd_mode_ff <= aqu_pkg::fwd_mode_type'(csr_wdata[1:0]);
            end
            aqu_pkg::CSR_BACKWARD_MODE: begin
               bwd_mode_ff <= aqu_pkg::bwd_mode_type'(csr_wdata[0]);
            end
            aqu_pkg::CSR_NEGATIVE_SLOPE: begin
               slope_ff <= csr_wdata[DW-1:0];
            end
            aqu_pkg::CSR_CLIP_THRESHOLD: begin
               thr_ff <= csr_wdata[DW-2:0];
            end
            aqu_pkg::CSR_CENTER_COUNT: begin
               count_ff <= csr_wdata[aqu_pkg::RAW_COUNT_W-1:0];
            end
            aqu_pkg::CSR_CENTER_TABLE: begin
               table_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // zero acts as one, anything above the slot count as the slot count
   assign count_wide = aqu_pkg::COUNT_W'(count_ff);

   always_comb begin
      ctrl.fwd_mode = fwd_mode_ff;
      ctrl.bwd_mode = bwd_mode_ff;
      if (count_ff == '0) begin
         ctrl.center_count = aqu_pkg::COUNT_W'(1);
      end else if (count_wide > aqu_pkg::COUNT_W'(SLOTS)) begin
         ctrl.center_count = aqu_pkg::COUNT_W'(SLOTS);
      end else begin
         ctrl.center_count = count_wide;
      end
   end

   assign slope = slope_ff;
   assign thr   = thr_ff;

   // slots past the end of the table read as zero
   for (genvar j = 0; j < SLOTS; j++) begin : g_center
      assign centers[j] = DW'(table_ff >> (DW * j));
   end

endmodule

/* src/aqu_cmp_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqu_cmp_stage
// Stage one: input capture with all range, clip and center-midpoint compares.
// ----------------------------------------------------------------------------
module aqu_cmp_stage #(
   parameter int DW    = aqu_pkg::DATA_WIDTH,
   parameter int FRAC  = aqu_pkg::FRAC_BITS,
   parameter int SLOTS = aqu_pkg::CENTER_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  aqu_pkg::req_kind_type  in_kind,
   input  logic signed [DW-1:0]   in_x,
   input  logic signed [DW-1:0]   in_g,
   input  aqu_pkg::ctrl_type      ctrl,
   input  logic [DW-2:0]          thr,
   input  logic signed [DW-1:0]   centers [SLOTS],
   output logic                   out_valid,
   input  logic                   out_ready,
   output aqu_pkg::req_kind_type  out_kind,
   output logic signed [DW-1:0]   out_x,
   output logic signed [DW-1:0]   out_g,
   output aqu_pkg::flags_type     out_flags,
   output logic [SLOTS-1:0]       out_pick
);

   localparam longint ONE_L = 64'sd1 <<< FRAC;

   logic                  valid_ff, valid_in;
   aqu_pkg::req_kind_type kind_ff;
   logic signed [DW-1:0]  x_ff, g_ff;
   aqu_pkg::flags_type    flags_ff, flags_in;
   logic [SLOTS-1:0]      pick_ff, pick_in, hit, last;
   logic signed [DW:0]    x_ext, thr_ext;
   logic signed [DW+1:0]  twice_x;
   longint                x_l;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign x_l     = longint'(in_x);
   assign x_ext   = (DW+1)'(in_x);
   assign thr_ext = $signed({2'b00, thr});
   assign twice_x = $signed({in_x[DW-1], in_x, 1'b0});

   always_comb begin
      flags_in.x_pos     = in_x > 0;
      flags_in.x_gt_one  = x_l > ONE_L;
      flags_in.x_lt_mone = x_l < -ONE_L;
      flags_in.clip_pass = (thr == '0) || ((x_ext >= -thr_ext) && (x_ext <= thr_ext));
      flags_in.over_thr  = (thr != '0) && (x_ext > thr_ext);
   end

   // hit: x at or below the midpoint of centers j and j+1 (2x against their sum), in range
   for (genvar j = 0; j < SLOTS; j++) begin : g_pick
      if (j < SLOTS - 1) begin : g_pair
         logic signed [DW+1:0] mid_sum;
         assign mid_sum = (DW+2)'(centers[j]) + (DW+2)'(centers[j+1]);
         assign hit[j]  = (twice_x <= mid_sum) &&
                          (aqu_pkg::COUNT_W'(j + 1) < ctrl.center_count);
      end else begin : g_end
         assign hit[j] = 1'b0;
      end
      assign last[j] = ctrl.center_count == aqu_pkg::COUNT_W'(j + 1);
   end

   assign pick_in = hit | last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         kind_ff  <= in_kind;
         x_ff     <= in_x;
         g_ff     <= in_g;
         flags_ff <= flags_in;
         pick_ff  <= pick_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_x     = x_ff;
   assign out_g     = g_ff;
   assign out_flags = flags_ff;
   assign out_pick  = pick_ff;

endmodule

/* src/aqu_mul_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqu_mul_stage
// Stage two: slope product and selection of the non-product result.
// ----------------------------------------------------------------------------
module aqu_mul_stage #(
   parameter int DW    = aqu_pkg::DATA_WIDTH,
   parameter int FRAC  = aqu_pkg::FRAC_BITS,
   parameter int SLOTS = aqu_pkg::CENTER_SLOTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  aqu_pkg::req_kind_type   in_kind,
   input  logic signed [DW-1:0]    in_x,
   input  logic signed [DW-1:0]    in_g,
   input  aqu_pkg::flags_type      in_flags,
   input  logic [SLOTS-1:0]        in_pick,
   input  aqu_pkg::ctrl_type       ctrl,
   input  logic signed [DW-1:0]    slope,
   input  logic signed [DW-1:0]    centers [SLOTS],
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [2*DW-1:0]  out_prod,
   output logic signed [DW-1:0]    out_base,
   output aqu_pkg::sel_type        out_sel
);

   localparam longint MAX_L   = (64'sd1 <<< (DW - 1)) - 64'sd1;
   localparam longint MIN_L   = -MAX_L - 64'sd1;
   localparam longint ONE_L   = 64'sd1 <<< FRAC;
   localparam longint ONE_P_L = (ONE_L > MAX_L) ? MAX_L : ONE_L;
   localparam longint ONE_N_L = (-ONE_L < MIN_L) ? MIN_L : -ONE_L;
   localparam logic signed [DW-1:0] ONE_POS = DW'(ONE_P_L);
   localparam logic signed [DW-1:0] ONE_NEG = DW'(ONE_N_L);
   localparam logic signed [DW-1:0] MAX_V   = DW'(MAX_L);
   localparam logic signed [DW-1:0] MIN_V   = DW'(MIN_L);

   logic                   valid_ff, valid_in;
   logic signed [2*DW-1:0] prod_ff, prod_in;
   logic signed [DW-1:0]   base_ff, base_in;
   aqu_pkg::sel_type       sel_ff, sel_in;
   logic signed [DW-1:0]   operand, center_sel, neg_slope;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign operand   = (in_kind == aqu_pkg::REQ_BACKWARD) ? in_g : in_x;
   assign prod_in   = slope * operand;
   assign neg_slope = (slope == MIN_V) ? MAX_V : -slope;

   // lowest picked slot wins
   always_comb begin
      center_sel = centers[0];
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (in_pick[j]) begin
            center_sel = centers[j];
         end
      end
   end

   always_comb begin
      base_in         = in_x;
      sel_in.use_prod = 1'b0;
      sel_in.zero     = 1'b0;
      if (in_kind == aqu_pkg::REQ_FORWARD) begin
         unique case (ctrl.fwd_mode)
            aqu_pkg::FWD_SIGN: begin
               base_in = in_x[DW-1] ? ONE_NEG : ONE_POS;
            end
            aqu_pkg::FWD_HARDTANH: begin
               if (in_flags.x_gt_one) begin
                  base_in = ONE_POS;
               end else if (in_flags.x_lt_mone) begin
                  base_in = ONE_NEG;
               end else begin
                  base_in = in_x;
               end
            end
            aqu_pkg::FWD_HWGQ: begin
               base_in = in_flags.x_pos ? center_sel : neg_slope;
            end
            aqu_pkg::FWD_LEAKY: begin
               base_in         = in_x;
               sel_in.use_prod = !in_flags.x_pos;
            end
         endcase
      end else begin
         unique case (ctrl.bwd_mode)
            aqu_pkg::BWD_CLIP: begin
               base_in     = in_g;
               sel_in.zero = !in_flags.clip_pass;
            end
            aqu_pkg::BWD_LEAKY: begin
               base_in         = in_g;
               sel_in.use_prod = !in_flags.x_pos;
               sel_in.zero     = in_flags.over_thr;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
         sel_ff  <= sel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_base  = base_ff;
   assign out_sel   = sel_ff;

endmodule

/* src/aqu_round_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqu_round_stage
// Stage three: product rounding and saturation, final select, output register.
// ----------------------------------------------------------------------------
module aqu_round_stage #(
   parameter int DW   = aqu_pkg::DATA_WIDTH,
   parameter int FRAC = aqu_pkg::FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [2*DW-1:0]  in_prod,
   input  logic signed [DW-1:0]    in_base,
   input  aqu_pkg::sel_type        in_sel,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [DW-1:0]           out_result
);

   localparam int     SUM_W  = (2 * DW + 1 > FRAC + 2) ? 2 * DW + 1 : FRAC + 2;
   localparam longint HALF_L = (64'sd1 <<< FRAC) >>> 1;
   localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(HALF_L);
   localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'((64'sd1 <<< (DW - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] MIN_S = -MAX_S - SUM_W'(1);

   logic                   valid_ff, valid_in;
   logic [DW-1:0]          result_ff, result_in;
   logic signed [SUM_W-1:0] sum, scaled;
   logic signed [DW-1:0]   prod_sat;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // round to nearest, ties up, by floor of (p + half)
   assign sum    = SUM_W'(in_prod) + HALF;
   assign scaled = sum >>> FRAC;

   always_comb begin
      if (scaled > MAX_S) begin
         prod_sat = DW'(MAX_S);
      end else if (scaled < MIN_S) begin
         prod_sat = DW'(MIN_S);
      end else begin
         prod_sat = DW'(scaled);
      end
   end

   always_comb begin
      priority if (in_sel.zero) begin
         result_in = '0;
      end else if (in_sel.use_prod) begin
         result_in = prod_sat;
      end else begin
         result_in = in_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

/* src/activation_quantizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// activation_quantizer_unit
// Element-wise activation quantizer and gradient unit on signed fixed point.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A forward beat maps x through sign, hard tanh,
// the half-wave Gaussian quantizer or leaky ReLU; a backward beat turns the
// upstream gradient into the input gradient by clip pass or leaky ReLU
// slope. The datapath is three register stages (compares, slope multiply,
// round and saturate into the output register); one beat is accepted every
// cycle while the result side keeps taking, and each stage holds one beat
// and moves on as soon as the stage after it has room. The user must write
// registers on the csr port only while nothing is in flight; the block
// does not enforce this. They take effect on the next beat.
module activation_quantizer_unit #(
   parameter int CENTER_SLOTS = aqu_pkg::CENTER_SLOTS,
   parameter int DATA_WIDTH   = aqu_pkg::DATA_WIDTH,
   parameter int FRAC_BITS    = aqu_pkg::FRAC_BITS,
   localparam int REQ_W = ((2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_W-1:0]                   req_tdata,   // value_in, grad_in
   input  logic [0:0]                         req_tuser,   // req_type
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_W-1:0]                   rsp_tdata,   // result_value
   // register write port
   input  logic                               csr_we,
   input  logic [aqu_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [aqu_pkg::TABLE_WIDTH-1:0]    csr_wdata
);

   localparam int DW = DATA_WIDTH;

   // register file outputs
   aqu_pkg::ctrl_type      ctrl;
   logic signed [DW-1:0]   slope;
   logic [DW-2:0]          thr;
   logic signed [DW-1:0]   centers [CENTER_SLOTS];

   // stage one to two
   logic                   s1_valid, s1_ready;
   aqu_pkg::req_kind_type  s1_kind;
   logic signed [DW-1:0]   s1_x, s1_g;
   aqu_pkg::flags_type     s1_flags;
   logic [CENTER_SLOTS-1:0] s1_pick;

   // stage two to three
   logic                   s2_valid, s2_ready;
   logic signed [2*DW-1:0] s2_prod;
   logic signed [DW-1:0]   s2_base;
   aqu_pkg::sel_type       s2_sel;

   logic [DW-1:0]          result;

   aqu_csr #(
      .DW    (DW),
      .SLOTS (CENTER_SLOTS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .slope     (slope),
      .thr       (thr),
      .centers   (centers)
   );

   // compares and center midpoint tests
   aqu_cmp_stage #(
      .DW    (DW),
      .FRAC  (FRAC_BITS),
      .SLOTS (CENTER_SLOTS)
   ) u_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (aqu_pkg::req_kind_type'(req_tuser[0])),
      .in_x      (req_tdata[DW-1:0]),
      .in_g      (req_tdata[2*DW-1:DW]),
      .ctrl      (ctrl),
      .thr       (thr),
      .centers   (centers),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_kind  (s1_kind),
      .out_x     (s1_x),
      .out_g     (s1_g),
      .out_flags (s1_flags),
      .out_pick  (s1_pick)
   );

   // slope multiply and mode select
   aqu_mul_stage #(
      .DW    (DW),
      .FRAC  (FRAC_BITS),
      .SLOTS (CENTER_SLOTS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_kind   (s1_kind),
      .in_x      (s1_x),
      .in_g      (s1_g),
      .in_flags  (s1_flags),
      .in_pick   (s1_pick),
      .ctrl      (ctrl),
      .slope     (slope),
      .centers   (centers),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_prod  (s2_prod),
      .out_base  (s2_base),
      .out_sel   (s2_sel)
   );

   // round, saturate, output register
   aqu_round_stage #(
      .DW   (DW),
      .FRAC (FRAC_BITS)
   ) u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_ready   (s2_ready),
      .in_prod    (s2_prod),
      .in_base    (s2_base),
      .in_sel     (s2_sel),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   // zero fill up to whole bytes
   assign rsp_tdata = RSP_W'(result);

`ifndef ASSERT_OFF
   // a draining result side must leave room for a new beat at the input
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request side stalled while result side drains");

   // an unbounded clip threshold must let every beat pass the clip test
   a_clip_open: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && thr == '0) |-> s1_flags.clip_pass)
      else $error("clip test failed with no threshold set");

   // at least one center slot ends the hwgq search
   a_pick_end: assert property (@(posedge clock) disable iff (reset)
      s1_valid |-> (s1_pick != '0))
      else $error("hwgq center pick is empty");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
